/* hdl/double_ended_queue_assert.svh */
// Assertion macros shared by the double-ended queue checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/deq_pkg.sv */
// Package for the double-ended queue: default sizes, operation and status codes,
// and the command struct that drives the storage cells. No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int ELEM_WIDTH = 32;

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;
    localparam logic [2:0] OP_REPORT     = 3'd5;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;

    // Moves applied to the cell row at a clock edge; at most one bit is set.
    typedef struct packed {
        logic push_front;
        logic pop_front;
        logic push_back;
    } t_cell_cmd;

endpackage

/* hdl/deq_cell.sv */
// One storage cell of the double-ended queue row; holds one element.
// Depends on deq_pkg for the cell command struct.
`timescale 1ns / 1ps

module deq_cell #(
    parameter int W = deq_pkg::ELEM_WIDTH
) (
    input  logic               i_clk,
    input  deq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occ_left,
    input  logic               i_occ_self,
    input  logic               i_occ_right,
    input  logic [W-1:0]       i_left_data,
    input  logic [W-1:0]       i_right_data,
    input  logic [W-1:0]       i_value,
    output logic [W-1:0]       o_data,
    output logic [W-1:0]       o_back_term
);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    // A push at the front shifts every element one cell toward the back, a pop at
    // the front shifts them toward the front. A push at the back lands in the first
    // free cell, the one whose left neighbor is occupied.
    always_comb begin
        n_data = r_data;
        if (i_cmd.push_front) begin
            n_data = i_left_data;
        end else if (i_cmd.pop_front) begin
            n_data = i_right_data;
        end else if (i_cmd.push_back && i_occ_left && !i_occ_self) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_back_term = (i_occ_self && !i_occ_right) ? r_data : '0;

endmodule

/* hdl/double_ended_queue.sv */
// Top level of the double-ended queue: handshake, operation decode, count,
// cell row and result register. Depends on deq_pkg and deq_cell.
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  ----------------------------------
//  request   in         i_in_valid / o_in_ready     i_op, i_value
//  result    out        o_out_valid / i_out_ready   o_status, o_count, o_is_empty,
//                                                   o_is_full, o_front_value,
//                                                   o_back_value
//
// For each request word, at the accepting edge the cell row and the count update,
// and at the next edge the result register loads from the new state.
// A new word is not taken while the previous one is still forming its result.
// The result register parts the two sides: a stalled result blocks only new words.
// Reset clears the count, the busy flag and the result valid, and holds the request
// side not ready; cell contents need no reset and there is no clearing pass.
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH,
    parameter int ELEM_WIDTH = deq_pkg::ELEM_WIDTH,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_op,
    input  logic [ELEM_WIDTH-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [CW-1:0]         o_count,
    output logic                  o_is_empty,
    output logic                  o_is_full,
    output logic [ELEM_WIDTH-1:0] o_front_value,
    output logic [ELEM_WIDTH-1:0] o_back_value
);

    // Control state.
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_busy;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic          r_out_valid;

    // Result register payload.
    logic [1:0]            r_out_status;
    logic [CW-1:0]         r_out_count;
    logic                  r_out_empty;
    logic                  r_out_full;
    logic [ELEM_WIDTH-1:0] r_out_front;
    logic [ELEM_WIDTH-1:0] r_out_back;

    logic               accept;
    logic               full;
    logic               empty;
    deq_pkg::t_cell_cmd cmd;

    // Occupancy of each cell in thermometer form, plus the cell row's data.
    logic [DEPTH-1:0]      occ;
    logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
    logic [ELEM_WIDTH-1:0] back_term [DEPTH];
    logic [ELEM_WIDTH-1:0] back_or;
    logic [ELEM_WIDTH-1:0] front_val;

    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);

    // A word is taken only out of reset, when no result is being formed and the
    // result register is free or is being emptied at this edge.
    assign o_in_ready = i_rst_n && !r_busy && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Operation decode. A rejected push or pop leaves the cells and the count
    // alone; clear only resets the count, since the cells past the count are dead.
    // Unused codes behave as report only.
    always_comb begin
        n_status = deq_pkg::ST_DONE;
        n_count  = r_count;
        cmd      = '0;
        unique case (i_op)
            deq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    cmd.push_back = 1'b1;
                    n_count       = r_count + CW'(1);
                end
            end
            deq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    cmd.push_front = 1'b1;
                    n_count        = r_count + CW'(1);
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    cmd.pop_front = 1'b1;
                    n_count       = r_count - CW'(1);
                end
            end
            deq_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (!accept) begin
            cmd = '0;
        end
    end

    // The cell row. Cell zero always holds the front element; the element count
    // decides which cells are live, and the last live cell holds the back element.
    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(g);

            logic                  occ_left;
            logic                  occ_right;
            logic [ELEM_WIDTH-1:0] left_data;
            logic [ELEM_WIDTH-1:0] right_data;

            assign occ[g] = (IDX < r_count);

            if (g == 0) begin : g_first
                assign occ_left  = 1'b1;
                assign left_data = i_value;
            end else begin : g_inner_left
                assign occ_left  = occ[g-1];
                assign left_data = cell_data[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign occ_right  = 1'b0;
                assign right_data = '0;
            end else begin : g_inner_right
                assign occ_right  = occ[g+1];
                assign right_data = cell_data[g+1];
            end

            deq_cell #(
                .W (ELEM_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_occ_left   (occ_left),
                .i_occ_self   (occ[g]),
                .i_occ_right  (occ_right),
                .i_left_data  (left_data),
                .i_right_data (right_data),
                .i_value      (i_value),
                .o_data       (cell_data[g]),
                .o_back_term  (back_term[g])
            );
        end
    endgenerate

    // Only the last live cell drives a nonzero back term, so an OR over the row
    // selects the back element, and gives zero when the queue is empty.
    always_comb begin
        back_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            back_or = back_or | back_term[k];
        end
    end

    assign front_val = occ[0] ? cell_data[0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= accept;
            if (accept) begin
                r_count <= n_count;
            end
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status is registered when the word is taken and passed on to the result register;
    // the rest of the result is read from the updated cells and count.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
        if (r_busy) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_empty  <= empty;
            r_out_full   <= full;
            r_out_front  <= front_val;
            r_out_back   <= back_or;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_count       = r_out_count;
    assign o_is_empty    = r_out_empty;
    assign o_is_full     = r_out_full;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;

endmodule

/* hdl/deq_checker.sv */
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg and the macros in double_ended_queue_assert.svh.
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"

module deq_checker #(
    parameter int DEPTH      = deq_pkg::DEPTH,
    parameter int ELEM_WIDTH = deq_pkg::ELEM_WIDTH,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [2:0]            i_op,
    input logic [ELEM_WIDTH-1:0] i_value,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [1:0]            o_status,
    input logic [CW-1:0]         o_count,
    input logic                  o_is_empty,
    input logic                  o_is_full,
    input logic [ELEM_WIDTH-1:0] o_front_value,
    input logic [ELEM_WIDTH-1:0] o_back_value
);

    // A stalled result word keeps its valid and its count.
    `DQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_count), "stalled result word changed")

    // An empty queue reports zero at both ends.
    `DQ_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_out_valid && o_is_empty,
        o_count == '0 && o_front_value == '0 && o_back_value == '0,
        "empty result with nonzero count or end values")

    // A rejected push leaves the queue full, a rejected pop leaves it empty.
    `DQ_ASSERT_IMP(a_reject_flags, i_clk, i_rst_n, o_out_valid,
        (o_status != deq_pkg::ST_FULL || o_is_full) &&
        (o_status != deq_pkg::ST_EMPTY || o_is_empty), "reject status disagrees with flags")

    // A taken word is in flight until its result is formed, so no second word follows at once.
    `DQ_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "request taken while the previous word is in flight")

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
) u_deq_checker (.*);
